// ===== hw/rtl/disp_pkg.sv =====
// Shared types, codes and constants of the disk image stream parser.
package disp_pkg;

  // Default limits handed to the top level's parameters.
  localparam int MAX_SECTORS_DEF   = 29;
  localparam int MAX_SIZE_CODE_DEF = 6;

  // Fixed header offsets.
  localparam logic [13:0] FILE_SIG_LEN  = 14'd21;
  localparam logic [13:0] TRACK_SIG_LEN = 14'd10;
  localparam logic [13:0] OFS_TRACKS    = 14'h30;
  localparam logic [13:0] OFS_HEADS     = 14'h31;
  localparam logic [13:0] OFS_TRACK_NUM = 14'h10;
  localparam logic [13:0] OFS_HEAD_NUM  = 14'h11;
  localparam logic [13:0] OFS_SECTORS   = 14'h15;
  localparam logic [13:0] OFS_ID_TABLE  = 14'h18;
  localparam logic [13:0] OFS_HDR_LAST  = 14'hFF;
  localparam logic [14:0] BASE_SECTOR_LEN = 15'd128;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_FILE_SIG  = 3'd1;
  localparam logic [2:0] ERR_TRACK_SIG = 3'd2;
  localparam logic [2:0] ERR_EARLY_END = 3'd3;
  localparam logic [2:0] ERR_RANGE     = 3'd4;

  // File signatures, extended and standard form, and the track block signature.
  localparam logic [7:0] SIG_EXT [21] = '{
    8'h45, 8'h58, 8'h54, 8'h45, 8'h4E, 8'h44, 8'h45, 8'h44, 8'h20, 8'h43, 8'h50,
    8'h43, 8'h20, 8'h44, 8'h53, 8'h4B, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65};
  localparam logic [7:0] SIG_STD [21] = '{
    8'h4D, 8'h56, 8'h20, 8'h2D, 8'h20, 8'h43, 8'h50, 8'h43, 8'h45, 8'h4D, 8'h55,
    8'h20, 8'h44, 8'h69, 8'h73, 8'h6B, 8'h2D, 8'h46, 8'h69, 8'h6C, 8'h65};
  localparam logic [7:0] SIG_TRK [10] = '{
    8'h54, 8'h72, 8'h61, 8'h63, 8'h6B, 8'h2D, 8'h49, 8'h6E, 8'h66, 8'h6F};

  typedef enum logic [4:0] {
    PH_FILE     = 5'b00001,
    PH_TRACK    = 5'b00010,
    PH_DATA     = 5'b00100,
    PH_PENDING  = 5'b01000,
    PH_FINISHED = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_end;
  } byte_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       extended_format;
    logic [7:0] track_number;
    logic [7:0] head_number;
    logic [4:0] sector_index;
    logic [7:0] sector_cyl;
    logic [7:0] sector_head;
    logic [7:0] sector_record;
    logic [2:0] size_code;
    logic [7:0] sector_byte;
    logic       last_in_sector;
  } result_item_t;

endpackage

// ===== hw/rtl/disk_image_stream_parser.sv =====
// Disk image stream parser: one image byte in, at most one result out, per transaction.
//
// The byte channel (byte_valid, byte_ready, byte_item) carries the image one byte per
// transaction; image_end marks the last byte. The result channel (result_valid,
// result_ready, result_item) carries one sector data byte tagged with its sector ID,
// or a single done or error result that ends the run.
// Every byte is parsed in the cycle it is accepted and its result, if any, sits in
// the output register on the next cycle; one byte per cycle while no result is stalled.
// byte_ready is high whenever the output register is empty or being emptied, so a
// stalled receiver holds back the byte channel only while a result waits.
// Bytes that cause no result (headers, trailing bytes) leave the output untouched.
// After the done or error result every byte is taken and dropped until reset.
// The byte after the final data byte carries the done result and is otherwise ignored.
// Reset (rst, synchronous) returns the parser to the start of the file header and
// empties the output register; the sector ID buffer needs no clearing, as every entry
// is written by a track header before it is read.
module disk_image_stream_parser #(
  parameter int MAX_SECTORS   = disp_pkg::MAX_SECTORS_DEF,
  parameter int MAX_SIZE_CODE = disp_pkg::MAX_SIZE_CODE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  disp_pkg::byte_item_t   byte_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output disp_pkg::result_item_t result_item
);
  import disp_pkg::*;

  localparam int          IdxW      = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam logic [5:0]  SlotLim   = 6'(MAX_SECTORS);
  localparam logic [7:0]  SectorLim = 8'(MAX_SECTORS);
  localparam logic [7:0]  SizeLim   = 8'(MAX_SIZE_CODE);

  phase_t       phase, phase_next;
  logic [13:0]  pos, pos_next;
  logic [1:0]   cands, cands_next;
  logic         ext_seen, ext_seen_next;
  logic [7:0]   track_total, track_total_next;
  logic [7:0]   head_total, head_total_next;
  logic [15:0]  blocks_left, blocks_left_next;
  logic [7:0]   cur_track, cur_track_next;
  logic [7:0]   cur_head, cur_head_next;
  logic [4:0]   sectors_in_track, sectors_in_track_next;
  logic [4:0]   sector_counter, sector_counter_next;

  // Sector ID buffer, one entry per sector slot.
  logic [7:0]   id_cyl  [MAX_SECTORS];
  logic [7:0]   id_head [MAX_SECTORS];
  logic [7:0]   id_rec  [MAX_SECTORS];
  logic [2:0]   id_size [MAX_SECTORS];

  logic         accept;
  logic [7:0]   b;
  logic         tbl_we;
  logic [1:0]   tbl_sub;
  logic [4:0]   tbl_slot;
  logic [7:0]   id_ofs;
  logic [IdxW-1:0] rd_idx;
  logic [14:0]  sector_len;
  logic [14:0]  pos_inc;
  logic         last;
  logic [4:0]   counter_inc;
  logic [1:0]   cand_tmp;
  logic [2:0]   err;
  logic         done;
  logic         data_out;
  logic         res_produce;
  result_item_t res_next;

  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_item.data_byte;

  assign id_ofs      = pos[7:0] - OFS_ID_TABLE[7:0];
  assign rd_idx      = ({1'b0, sector_counter} < SlotLim) ? sector_counter[IdxW-1:0] : '0;
  assign sector_len  = BASE_SECTOR_LEN << id_size[rd_idx];
  assign pos_inc     = {1'b0, pos} + 15'd1;
  assign last        = pos_inc >= sector_len;
  assign counter_inc = sector_counter + 5'd1;

  always_comb begin
    phase_next            = phase;
    pos_next              = pos;
    cands_next            = cands;
    ext_seen_next         = ext_seen;
    track_total_next      = track_total;
    head_total_next       = head_total;
    blocks_left_next      = blocks_left;
    cur_track_next        = cur_track;
    cur_head_next         = cur_head;
    sectors_in_track_next = sectors_in_track;
    sector_counter_next   = sector_counter;
    tbl_we                = 1'b0;
    tbl_sub               = id_ofs[1:0];
    tbl_slot              = id_ofs[7:3];
    cand_tmp              = cands;
    err                   = ERR_NONE;
    done                  = 1'b0;
    data_out              = 1'b0;
    res_produce           = 1'b0;
    res_next              = '0;

    case (phase)
      PH_FILE: begin
        if (pos < FILE_SIG_LEN) begin
          cand_tmp = cands & ~{b != SIG_STD[pos[4:0]], b != SIG_EXT[pos[4:0]]};
          cands_next = cand_tmp;
          if (cand_tmp == 2'b00) begin
            err = ERR_FILE_SIG;
          end else if (pos == FILE_SIG_LEN - 14'd1) begin
            ext_seen_next = cand_tmp[0];
          end
        end
        if (pos == OFS_TRACKS) track_total_next = b;
        if (pos == OFS_HEADS)  head_total_next  = b;
        if (err == ERR_NONE) begin
          if (pos == OFS_HDR_LAST) begin
            pos_next         = '0;
            blocks_left_next = track_total * head_total;
            if (blocks_left_next == 16'd0) begin
              done = 1'b1;
            end else begin
              phase_next = PH_TRACK;
            end
          end else begin
            pos_next = pos + 14'd1;
          end
        end
      end
      PH_TRACK: begin
        if (pos < TRACK_SIG_LEN && b != SIG_TRK[pos[3:0]]) err = ERR_TRACK_SIG;
        if (pos == OFS_TRACK_NUM) cur_track_next = b;
        if (pos == OFS_HEAD_NUM)  cur_head_next  = b;
        if (pos == OFS_SECTORS) begin
          if (b > SectorLim) begin
            err = ERR_RANGE;
          end else begin
            sectors_in_track_next = b[4:0];
          end
        end
        // ID entries are 8 bytes apart; only C, H, R and N are kept.
        if (pos >= OFS_ID_TABLE && !id_ofs[2] && {1'b0, tbl_slot} < SlotLim) begin
          tbl_we = 1'b1;
          if (tbl_sub == 2'd3 && tbl_slot < sectors_in_track && b > SizeLim) begin
            err = ERR_RANGE;
          end
        end
        if (err == ERR_NONE) begin
          if (pos == OFS_HDR_LAST) begin
            pos_next            = '0;
            sector_counter_next = '0;
            if (sectors_in_track == 5'd0) begin
              blocks_left_next = blocks_left - 16'd1;
              if (blocks_left_next == 16'd0) done = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            pos_next = pos + 14'd1;
          end
        end
      end
      PH_DATA: begin
        data_out = 1'b1;
        if (last) begin
          pos_next            = '0;
          sector_counter_next = counter_inc;
          if (counter_inc >= sectors_in_track) begin
            blocks_left_next = blocks_left - 16'd1;
            phase_next = (blocks_left_next == 16'd0) ? PH_PENDING : PH_TRACK;
          end
        end else begin
          pos_next = pos_inc[13:0];
        end
      end
      PH_PENDING: begin
        done = 1'b1;
      end
      PH_FINISHED: begin
      end
      default: begin
      end
    endcase

    if (err != ERR_NONE || done ||
        (byte_item.image_end && phase != PH_FINISHED && phase != PH_PENDING &&
         phase_next != PH_PENDING)) begin
      res_produce              = 1'b1;
      phase_next               = PH_FINISHED;
      res_next.kind            = (err == ERR_NONE && done) ? KIND_DONE : KIND_ERROR;
      res_next.error_code      = (err != ERR_NONE) ? err : (done ? ERR_NONE : ERR_EARLY_END);
      res_next.extended_format = ext_seen_next;
      res_next.track_number    = cur_track_next;
      res_next.head_number     = cur_head_next;
    end else if (data_out) begin
      res_produce              = 1'b1;
      res_next.kind            = KIND_DATA;
      res_next.error_code      = ERR_NONE;
      res_next.extended_format = ext_seen;
      res_next.track_number    = cur_track;
      res_next.head_number     = cur_head;
      res_next.sector_index    = sector_counter;
      res_next.sector_cyl      = id_cyl[rd_idx];
      res_next.sector_head     = id_head[rd_idx];
      res_next.sector_record   = id_rec[rd_idx];
      res_next.size_code       = id_size[rd_idx];
      res_next.sector_byte     = b;
      res_next.last_in_sector  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_FILE;
      pos              <= '0;
      cands            <= 2'b11;
      ext_seen         <= 1'b0;
      track_total      <= '0;
      head_total       <= '0;
      blocks_left      <= '0;
      cur_track        <= '0;
      cur_head         <= '0;
      sectors_in_track <= '0;
      sector_counter   <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        pos              <= pos_next;
        cands            <= cands_next;
        ext_seen         <= ext_seen_next;
        track_total      <= track_total_next;
        head_total       <= head_total_next;
        blocks_left      <= blocks_left_next;
        cur_track        <= cur_track_next;
        cur_head         <= cur_head_next;
        sectors_in_track <= sectors_in_track_next;
        sector_counter   <= sector_counter_next;
        result_valid     <= res_produce;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_produce) begin
      result_item <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && tbl_we) begin
      case (tbl_sub)
        2'd0:    id_cyl[tbl_slot[IdxW-1:0]]  <= b;
        2'd1:    id_head[tbl_slot[IdxW-1:0]] <= b;
        2'd2:    id_rec[tbl_slot[IdxW-1:0]]  <= b;
        default: id_size[tbl_slot[IdxW-1:0]] <= b[2:0];
      endcase
    end
  end

endmodule

// ===== hw/rtl/disp_checker.sv =====
// Port-level checker for the disk image stream parser, with its bind.
module disp_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input disp_pkg::result_item_t result_item
);
  import disp_pkg::*;

  // A waiting result stays until its transaction completes.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before transaction");

  // The payload of a waiting result does not change.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_item))
    else $error("result payload changed while stalled");

  // The parser only back-pressures while a result is waiting.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> byte_ready)
    else $error("byte channel stalled with empty output");

  // Nothing follows a done or error result.
  a_end_is_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result_item.kind != KIND_DATA |=> !result_valid)
    else $error("result after end of run");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present after reset");

endmodule

bind disk_image_stream_parser disp_checker u_disp_checker (.*);
